// File: src/terminal_utf8_decoder_top_macros.svh
// assertion macros for the terminal utf8 decoder
// expects a clock named clock and a reset named reset in the using module
`ifndef TERMINAL_UTF8_DECODER_TOP_MACROS_SVH
`define TERMINAL_UTF8_DECODER_TOP_MACROS_SVH

// property that must hold at every edge outside reset
`define TU8_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define TU8_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: src/tu8_pkg.sv
// shared types and codes for the terminal utf8 decoder
// no dependencies
package tu8_pkg;

   // parser modes
   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_ESC_SEEN = 2'd1,
      MODE_ESC_SKIP = 2'd2,
      MODE_UTF8     = 2'd3
   } mode_type;

   // result kinds
   localparam logic [1:0] KIND_ASCII  = 2'd0;
   localparam logic [1:0] KIND_MULTI  = 2'd1;
   localparam logic [1:0] KIND_LATIN1 = 2'd2;
   localparam logic [1:0] KIND_ESCAPE = 2'd3;

   // byte codes
   localparam logic [7:0] BYTE_ESC     = 8'h1b;
   localparam logic [7:0] BYTE_BRACKET = 8'h5b;
   localparam logic [7:0] BYTE_LOWER_A = 8'h61;
   localparam logic [7:0] BYTE_LOWER_Z = 8'h7a;

   localparam int CP_WIDTH    = 21;
   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic [1:0]          kind;
   } result_type;

   // all results caused by one input word
   typedef struct packed {
      logic [2:0]                       count;
      result_type [MAX_RESULTS-1:0]     item;
   } bundle_type;

   // outcome of decoding a byte in idle mode
   typedef struct packed {
      logic       emit;
      result_type res;
      mode_type   mode;
      logic [1:0] need;
   } fresh_type;

endpackage

// File: src/tu8_decode.sv
// parser state and per-word decode into a bundle of up to four results
// depends on tu8_pkg and the assertion macro header
`include "terminal_utf8_decoder_top_macros.svh"

module tu8_decode
   import tu8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_chunk,
   output bundle_type bundle
);

   mode_type   mode_ff, mode_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] need_ff, need_in;
   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];

   fresh_type  fresh;
   logic       is_cont;
   logic       complete;
   logic       is_lower;
   logic       cut_off;
   logic [CP_WIDTH-1:0] multi_cp;

   // decode of a byte seen with no sequence open
   function automatic fresh_type fresh_decode(input logic [7:0] b, input logic eoc);
      fresh_type f;
      f      = '0;
      f.mode = MODE_IDLE;
      if (b == BYTE_ESC) begin
         if (eoc) begin
            f.emit = 1'b1;
            f.res  = '{code_point: CP_WIDTH'(BYTE_ESC), kind: KIND_ASCII};
         end else begin
            f.mode = MODE_ESC_SEEN;
         end
      end else if (!b[7]) begin
         f.emit = 1'b1;
         f.res  = '{code_point: CP_WIDTH'(b), kind: KIND_ASCII};
      end else if (b[7:6] == 2'b11 && b < 8'hf8) begin
         if (eoc) begin
            f.emit = 1'b1;
            f.res  = '{code_point: CP_WIDTH'(b), kind: KIND_LATIN1};
         end else begin
            f.mode = MODE_UTF8;
            f.need = (b < 8'he0) ? 2'd1 : (b < 8'hf0) ? 2'd2 : 2'd3;
         end
      end else begin
         f.emit = 1'b1;
         f.res  = '{code_point: CP_WIDTH'(b), kind: KIND_LATIN1};
      end
      return f;
   endfunction

   assign fresh    = fresh_decode(in_byte, end_of_chunk);
   assign is_cont  = (in_byte[7:6] == 2'b10);
   assign complete = (cnt_ff >= need_ff);
   assign is_lower = (in_byte >= BYTE_LOWER_A) && (in_byte <= BYTE_LOWER_Z);
   assign cut_off  = end_of_chunk || (cnt_ff == 2'd3);

   // assembled codepoint for a completed sequence
   always_comb begin
      if (need_ff <= 2'd1) begin
         multi_cp = CP_WIDTH'({pend_ff[0][4:0], in_byte[5:0]});
      end else if (need_ff == 2'd2) begin
         multi_cp = CP_WIDTH'({pend_ff[0][3:0], pend_ff[1][5:0], in_byte[5:0]});
      end else begin
         multi_cp = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0], in_byte[5:0]};
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      need_in = need_ff;
      pend_in = pend_ff;
      if (accept) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               mode_in = fresh.mode;
               if (fresh.mode == MODE_UTF8) begin
                  pend_in[0] = in_byte;
                  cnt_in     = 2'd1;
                  need_in    = fresh.need;
               end
            end
            MODE_ESC_SEEN: begin
               if (in_byte == BYTE_BRACKET) begin
                  mode_in = end_of_chunk ? MODE_IDLE : MODE_ESC_SKIP;
               end else begin
                  mode_in = fresh.mode;
                  if (fresh.mode == MODE_UTF8) begin
                     pend_in[0] = in_byte;
                     cnt_in     = 2'd1;
                     need_in    = fresh.need;
                  end
               end
            end
            MODE_ESC_SKIP: begin
               if (is_lower || end_of_chunk) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_UTF8: begin
               if (is_cont) begin
                  if (complete || cut_off) begin
                     mode_in = MODE_IDLE;
                     cnt_in  = 2'd0;
                     need_in = 2'd0;
                  end else begin
                     if (cnt_ff == 2'd1) begin
                        pend_in[1] = in_byte;
                     end else begin
                        pend_in[2] = in_byte;
                     end
                     cnt_in = cnt_ff + 2'd1;
                  end
               end else begin
                  // flush, then the breaking byte starts over
                  mode_in = fresh.mode;
                  cnt_in  = 2'd0;
                  need_in = 2'd0;
                  if (fresh.mode == MODE_UTF8) begin
                     pend_in[0] = in_byte;
                     cnt_in     = 2'd1;
                     need_in    = fresh.need;
                  end
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // result bundle for the current word
   always_comb begin : out_blk
      logic [2:0] n;
      logic       flush;
      n      = 3'd0;
      flush  = 1'b0;
      bundle = '0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (fresh.emit) begin
               bundle.item[n[1:0]] = fresh.res;
               n = n + 3'd1;
            end
         end
         MODE_ESC_SEEN: begin
            if (in_byte == BYTE_BRACKET) begin
               if (end_of_chunk) begin
                  bundle.item[n[1:0]] = '{code_point: '0, kind: KIND_ESCAPE};
                  n = n + 3'd1;
               end
            end else begin
               bundle.item[n[1:0]] = '{code_point: CP_WIDTH'(BYTE_ESC), kind: KIND_ASCII};
               n = n + 3'd1;
               if (fresh.emit) begin
                  bundle.item[n[1:0]] = fresh.res;
                  n = n + 3'd1;
               end
            end
         end
         MODE_ESC_SKIP: begin
            if (is_lower || end_of_chunk) begin
               bundle.item[n[1:0]] = '{code_point: '0, kind: KIND_ESCAPE};
               n = n + 3'd1;
            end
         end
         MODE_UTF8: begin
            if (is_cont) begin
               if (complete) begin
                  bundle.item[n[1:0]] = '{code_point: multi_cp, kind: KIND_MULTI};
                  n = n + 3'd1;
               end else if (cut_off) begin
                  flush = 1'b1;
               end
            end else begin
               flush = 1'b1;
            end
            // held bytes go out as latin-1 in order
            if (flush) begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < cnt_ff) begin
                     bundle.item[n[1:0]] = '{code_point: CP_WIDTH'(pend_ff[i]),
                                             kind: KIND_LATIN1};
                     n = n + 3'd1;
                  end
               end
               if (is_cont) begin
                  bundle.item[n[1:0]] = '{code_point: CP_WIDTH'(in_byte), kind: KIND_LATIN1};
                  n = n + 3'd1;
               end else if (fresh.emit) begin
                  bundle.item[n[1:0]] = fresh.res;
                  n = n + 3'd1;
               end
            end
         end
         default: begin
            n = 3'd0;
         end
      endcase
      bundle.count = n;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cnt_ff  <= 2'd0;
         need_ff <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         need_ff <= need_in;
      end
   end

   // held sequence bytes
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   `TU8_ASSERT_IMPL(a_no_hold_outside_utf8, mode_ff != MODE_UTF8, cnt_ff == 2'd0,
      "bytes held outside a utf8 sequence")
   `TU8_ASSERT_IMPL(a_hold_within_need, mode_ff == MODE_UTF8,
      (cnt_ff != 2'd0) && (cnt_ff <= need_ff), "held byte count out of range")
   `TU8_ASSERT(a_bundle_bound, bundle.count <= 3'd4, "more than four results for one word")

endmodule

// File: src/tu8_rsp_buf.sv
// result register that hands out one bundle entry per word on the result side
// depends on tu8_pkg and the assertion macro header
`include "terminal_utf8_decoder_top_macros.svh"

module tu8_rsp_buf
   import tu8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  bundle_type          bundle,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CP_WIDTH-1:0] rsp_code_point,
   output logic [1:0]          rsp_kind,
   output logic                rsp_last
);

   result_type item_ff [MAX_RESULTS];
   logic [2:0] remain_ff, remain_in;
   logic [1:0] head_ff, head_in;
   logic       take;

   assign rsp_valid      = (remain_ff != 3'd0);
   assign take           = rsp_valid && !rsp_stall;
   assign can_load       = (remain_ff == 3'd0) || ((remain_ff == 3'd1) && take);
   assign rsp_code_point = item_ff[head_ff].code_point;
   assign rsp_kind       = item_ff[head_ff].kind;
   assign rsp_last       = (remain_ff == 3'd1);

   // read pointer and fill count
   always_comb begin
      remain_in = remain_ff;
      head_in   = head_ff;
      if (load) begin
         remain_in = bundle.count;
         head_in   = 2'd0;
      end else if (take) begin
         remain_in = remain_ff - 3'd1;
         head_in   = head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 3'd0;
         head_ff   <= 2'd0;
      end else begin
         remain_ff <= remain_in;
         head_ff   <= head_in;
      end
   end

   // result entries
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            item_ff[i] <= bundle.item[i];
         end
      end
   end

   `TU8_ASSERT(a_entries_in_range, ({2'b00, head_ff} + {1'b0, remain_ff}) <= 4'd4,
      "read pointer ran past the held results")
   `TU8_ASSERT_IMPL(a_load_when_drained, load,
      (remain_ff == 3'd0) || ((remain_ff == 3'd1) && !rsp_stall),
      "new bundle loaded over undelivered results")
   `TU8_ASSERT_IMPL(a_advance_on_take, take && !load && (remain_ff > 3'd1),
      ##1 (head_ff == $past(head_ff) + 2'd1), "read pointer did not advance")

endmodule

// File: src/terminal_utf8_decoder_top.sv
// top level of the terminal utf8 decoder
// depends on tu8_pkg, tu8_decode and tu8_rsp_buf
//
//   channel   direction   fields                            handshake
//   req_      in          in_byte[8], end_of_chunk[1]       req_valid / req_stall
//   rsp_      out         code_point[21], kind[2], last[1]  rsp_valid / rsp_stall
//
// a word is decoded in the cycle it is taken; its results appear on rsp_ in the following cycle
// a word giving n results holds rsp_ until all n are taken; req_ takes a new word in
//   the cycle the last leaves; unstalled, single-result bytes go at one word per cycle
// the result register and read pointer set the rate: one result per unstalled cycle
// a word that gives no result is taken and only updates the parser state
// synchronous active high reset returns the parser to idle and empties the results
module terminal_utf8_decoder_top
   import tu8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_chunk,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CP_WIDTH-1:0] rsp_code_point,
   output logic [1:0]          rsp_kind,
   output logic                rsp_last
);

   bundle_type bundle;
   logic       can_load;
   logic       accept;

   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   // parser and per-word decode
   tu8_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_chunk (req_end_of_chunk),
      .bundle       (bundle)
   );

   // result register and serializer
   tu8_rsp_buf u_rsp_buf (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .bundle         (bundle),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_kind       (rsp_kind),
      .rsp_last       (rsp_last)
   );

endmodule

// File: tb/sv/terminal_utf8_decoder_check.sv
// checker for the terminal utf8 decoder: watches both channels, decodes each taken word
// and compares every result taken on rsp_; depends on tu8_pkg
`timescale 1ns / 1ps
module terminal_utf8_decoder_check
   import tu8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_chunk,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CP_WIDTH-1:0] rsp_code_point,
   input  logic [1:0]          rsp_kind,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  owed_count
);

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic [1:0]          kind;
      logic                last;
   } code_result_type;

   // results still owed by the block, oldest first
   code_result_type owed_codes[$];
   // results of the word being decoded
   code_result_type word_codes[$];
   code_result_type due_code;
   code_result_type one_code;
   int              mismatch_total = 0;

   // decoder state as seen from outside
   mode_type     parse_state;
   logic [7:0]   held_bytes [3];
   logic [1:0]   held_count;
   logic [1:0]   cont_needed;

   task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_total++;
   endtask

   function void push_code(input logic [CP_WIDTH-1:0] cp, input logic [1:0] kind);
      word_codes.push_back('{cp, kind, 1'b0});
   endfunction

   // byte seen with no sequence under way
   function void decode_fresh_byte(input logic [7:0] b, input logic eoc);
      if (b == BYTE_ESC) begin
         if (eoc) push_code(CP_WIDTH'(BYTE_ESC), KIND_ASCII);
         else parse_state = MODE_ESC_SEEN;
      end else if (!b[7]) begin
         push_code(CP_WIDTH'(b), KIND_ASCII);
      end else if (b[7:6] == 2'b11 && b < 8'hf8) begin
         if (eoc) begin
            push_code(CP_WIDTH'(b), KIND_LATIN1);
         end else begin
            held_bytes[0] = b;
            held_count    = 2'd1;
            cont_needed   = (b < 8'he0) ? 2'd1 : (b < 8'hf0) ? 2'd2 : 2'd3;
            parse_state   = MODE_UTF8;
         end
      end else begin
         push_code(CP_WIDTH'(b), KIND_LATIN1);
      end
   endfunction

   // give back the held bytes of a failed sequence as latin-1
   function void spill_held();
      for (int i = 0; i < held_count; i++)
         push_code(CP_WIDTH'(held_bytes[i]), KIND_LATIN1);
      held_count  = 2'd0;
      cont_needed = 2'd0;
      parse_state = MODE_IDLE;
   endfunction

   // decode one taken word and queue the results it owes
   function void decode_word(input logic [7:0] b, input logic eoc);
      logic [CP_WIDTH-1:0] cp;
      word_codes.delete();
      case (parse_state)
         MODE_IDLE: begin
            decode_fresh_byte(b, eoc);
         end
         MODE_ESC_SEEN: begin
            parse_state = MODE_IDLE;
            if (b == BYTE_BRACKET) begin
               if (eoc) push_code('0, KIND_ESCAPE);
               else parse_state = MODE_ESC_SKIP;
            end else begin
               push_code(CP_WIDTH'(BYTE_ESC), KIND_ASCII);
               decode_fresh_byte(b, eoc);
            end
         end
         MODE_ESC_SKIP: begin
            if ((b >= BYTE_LOWER_A && b <= BYTE_LOWER_Z) || eoc) begin
               push_code('0, KIND_ESCAPE);
               parse_state = MODE_IDLE;
            end
         end
         default: begin
            if (b[7:6] == 2'b10) begin
               if (held_count >= cont_needed) begin
                  // sequence complete
                  if (cont_needed <= 2'd1)
                     cp = {10'd0, held_bytes[0][4:0], b[5:0]};
                  else if (cont_needed == 2'd2)
                     cp = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]};
                  else
                     cp = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0],
                           b[5:0]};
                  push_code(cp, KIND_MULTI);
                  held_count  = 2'd0;
                  cont_needed = 2'd0;
                  parse_state = MODE_IDLE;
               end else if (eoc || held_count == 2'd3) begin
                  // cut off by the chunk end
                  spill_held();
                  push_code(CP_WIDTH'(b), KIND_LATIN1);
               end else begin
                  held_bytes[held_count] = b;
                  held_count++;
               end
            end else begin
               // broken sequence, the breaking byte starts over
               spill_held();
               decode_fresh_byte(b, eoc);
            end
         end
      endcase
      for (int i = 0; i < word_codes.size(); i++) begin
         one_code      = word_codes[i];
         one_code.last = (i == word_codes.size() - 1);
         owed_codes.push_back(one_code);
      end
   endfunction

   // compare taken results, then decode the taken word
   always @(posedge clock) begin
      if (reset) begin
         parse_state = MODE_IDLE;
         held_count  = 2'd0;
         cont_needed = 2'd0;
         owed_codes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_codes.size() == 0) begin
               report_mismatch($sformatf("result with nothing owed: cp %h kind %0d last %0b",
                                         rsp_code_point, rsp_kind, rsp_last));
            end else begin
               due_code = owed_codes.pop_front();
               if (rsp_code_point !== due_code.code_point || rsp_kind !== due_code.kind ||
                   rsp_last !== due_code.last)
                  report_mismatch($sformatf(
                     "cp %h/%h kind %0d/%0d last %0b/%0b (got/expected)",
                     rsp_code_point, due_code.code_point, rsp_kind, due_code.kind,
                     rsp_last, due_code.last));
            end
         end
         if (req_valid && !req_stall)
            decode_word(req_in_byte, req_end_of_chunk);
      end
      owed_count <= owed_codes.size();
      fail_count <= mismatch_total;
   end

endmodule

// File: tb/sv/terminal_utf8_decoder_top_tb.sv
// testbench top for the terminal utf8 decoder: clock, reset, word stimulus and verdict
// depends on tu8_pkg, terminal_utf8_decoder_top and terminal_utf8_decoder_check
`timescale 1ns / 1ps
module terminal_utf8_decoder_top_tb;
   import tu8_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DIRECTED_LEN = 28;
   localparam int PHASE_WORDS  = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_in_byte = 8'd0;
   logic                req_end_of_chunk = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CP_WIDTH-1:0] rsp_code_point;
   logic [1:0]          rsp_kind;
   logic                rsp_last;

   int fail_count;
   int owed_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   terminal_utf8_decoder_top dut (.*);

   terminal_utf8_decoder_check decode_check (.*);

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("terminal_utf8_decoder_top regression: fail");
            $finish;
         end
      end
   end

   // offer one word after a random gap and hold it until taken
   task send_word(input logic [7:0] b, input logic eoc);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid        <= 1'b0;
         req_in_byte      <= 8'($urandom);
         req_end_of_chunk <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_end_of_chunk <= eoc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // stop sending until every owed result has come
   task drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
   endtask

   // one random unit: mostly well-formed sequences, some broken ones and noise
   task send_unit();
      int         pick;
      int         conts;
      int         body;
      logic [7:0] lead;
      logic [7:0] r;
      pick = $urandom_range(99);
      if (pick < 20) begin
         send_word(8'($urandom_range(127)), $urandom_range(3) == 0);
      end else if (pick < 55) begin
         // utf8 sequence, now and then cut off
         conts = $urandom_range(1, 3);
         case (conts)
            1:       lead = 8'(8'hc0 + $urandom_range(31));
            2:       lead = 8'(8'he0 + $urandom_range(15));
            default: lead = 8'(8'hf0 + $urandom_range(7));
         endcase
         send_word(lead, $urandom_range(15) == 0);
         for (int i = 1; i <= conts; i++)
            send_word(8'(8'h80 + $urandom_range(63)),
                      (i == conts) ? 1'($urandom_range(1)) : ($urandom_range(11) == 0));
      end else if (pick < 75) begin
         // vt escape with a short body
         send_word(BYTE_ESC, 1'b0);
         send_word(BYTE_BRACKET, $urandom_range(15) == 0);
         body = $urandom_range(4);
         for (int i = 0; i < body; i++) begin
            case ($urandom_range(3))
               0:       r = 8'(8'h30 + $urandom_range(9));
               1:       r = 8'h3b;
               2:       r = BYTE_ESC;
               default: r = 8'($urandom);
            endcase
            send_word(r, 1'b0);
         end
         if ($urandom_range(3) != 0)
            send_word(8'(BYTE_LOWER_A + $urandom_range(25)), 1'($urandom));
         else send_word(8'(8'h30 + $urandom_range(9)), 1'b1);
      end else if (pick < 82) begin
         // esc followed by something else
         r = 8'($urandom);
         if (r == BYTE_BRACKET) r = 8'h5c;
         send_word(BYTE_ESC, 1'b0);
         send_word(r, 1'($urandom));
      end else if (pick < 90) begin
         // broken sequence
         lead = 8'(8'hc0 + $urandom_range(55));
         send_word(lead, 1'b0);
         if ($urandom_range(1) && lead >= 8'he0)
            send_word(8'(8'h80 + $urandom_range(63)), 1'b0);
         r = 8'($urandom);
         if (r[7:6] == 2'b10) r[7] = 1'b0;
         send_word(r, 1'($urandom));
      end else begin
         send_word(8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the byte and chunk flag
      send_word(8'h00, 1'b0);
      send_word(8'h7f, 1'b1);
      send_word(8'hff, 1'b0);
      send_word(8'h80, 1'b0);
      // two, three and four byte sequences
      send_word(8'hc3, 1'b0);
      send_word(8'ha9, 1'b0);
      send_word(8'he2, 1'b0);
      send_word(8'h82, 1'b0);
      send_word(8'hac, 1'b1);
      send_word(8'hf7, 1'b0);
      send_word(8'hbf, 1'b0);
      send_word(8'hbf, 1'b0);
      send_word(8'hbf, 1'b0);
      // lead at chunk end
      send_word(8'hc3, 1'b1);
      // broken sequence with a held continuation
      send_word(8'he2, 1'b0);
      send_word(8'h82, 1'b0);
      send_word(8'h41, 1'b0);
      // sequence cut off by the chunk end
      send_word(8'hf0, 1'b0);
      send_word(8'h90, 1'b1);
      // esc at chunk end, esc then esc, escape body ending in a letter
      send_word(BYTE_ESC, 1'b1);
      send_word(BYTE_ESC, 1'b0);
      send_word(BYTE_ESC, 1'b0);
      send_word(BYTE_BRACKET, 1'b0);
      send_word(8'h31, 1'b0);
      send_word(BYTE_ESC, 1'b0);
      send_word(8'h6d, 1'b0);
      // esc bracket at chunk end
      send_word(BYTE_ESC, 1'b0);
      send_word(BYTE_BRACKET, 1'b1);

      drain_results();

      // random phases: free run, sender idle, receiver stall, both lightly
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 65; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 9;  stall_pct = 9;  end
         endcase
         while (words_sent < DIRECTED_LEN + PHASE_WORDS * (phase + 1)) send_unit();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && owed_count == 0) begin
         $display("terminal_utf8_decoder_top regression: pass");
      end else begin
         $display("terminal_utf8_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/tu8_pkg.sv
src/tu8_decode.sv
src/tu8_rsp_buf.sv
src/terminal_utf8_decoder_top.sv
tb/sv/terminal_utf8_decoder_check.sv
tb/sv/terminal_utf8_decoder_top_tb.sv
